@@ sv/pqt_pkg.sv @@
// ---------------------------------------------------------------------------
// pqt_pkg
// Shared constants and codes for the two-queue strict-priority transmitter.
// ---------------------------------------------------------------------------
package pqt_pkg;

  // default sizes
  localparam int NORMAL_DEPTH_DEF = 64;
  localparam int PRIO_DEPTH_DEF   = 16;
  localparam int HANDLE_BITS_DEF  = 16;

  // configuration port
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CAP_W       = 7;
  localparam int QID_W       = 2;
  localparam int LEN_W       = 7;
  localparam int DROP_W      = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_CAP = 2'd0,
    CFG_LB_EN     = 2'd1,
    CFG_QUEUE_IDX = 2'd2
  } cfg_reg_t;

  // request codes
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_FINISH  = 1'b1;

endpackage

@@ sv/priority_two_queue_transmitter.sv @@
// ---------------------------------------------------------------------------
// priority_two_queue_transmitter
// Output-link queue: idle link sends at once, otherwise control packets go to
// a priority FIFO and data packets to a tail-drop normal FIFO; a finished
// transmission serves the priority head first, then the normal head.
// ---------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start / busy       | req_type, pkt_handle, is_control
//  result    | done (1-cycle)     | tx_start, tx_handle, dropped, drop_total,
//            |                    | normal_len, link_busy, report_valid,
//            |                    | report_queue, report_len
//  config    | cfg_write          | cfg_index, cfg_data
//
//  One request per clock: all queue state updates at the accepting edge and
//  the FIFO head read from the synchronous RAMs lands at that same edge, so
//  the result strobe follows in the next cycle. Throughput is set by the single
//  read port of each FIFO RAM, read every cycle at its head pointer.
//  Synchronous reset empties both FIFOs by clearing counts and pointers; the
//  RAM contents need no clearing. The receiver cannot stall, so busy stays low.
// ---------------------------------------------------------------------------
module priority_two_queue_transmitter #(
  parameter int NORMAL_DEPTH = pqt_pkg::NORMAL_DEPTH_DEF,
  parameter int PRIO_DEPTH   = pqt_pkg::PRIO_DEPTH_DEF,
  parameter int HANDLE_BITS  = pqt_pkg::HANDLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type,
  input  logic [HANDLE_BITS-1:0]           pkt_handle,
  input  logic                             is_control,
  // result
  output logic                             done,
  output logic                             tx_start,
  output logic [HANDLE_BITS-1:0]           tx_handle,
  output logic                             dropped,
  output logic [pqt_pkg::DROP_W-1:0]       drop_total,
  output logic [pqt_pkg::LEN_W-1:0]        normal_len,
  output logic                             link_busy,
  output logic                             report_valid,
  output logic [pqt_pkg::QID_W-1:0]        report_queue,
  output logic [pqt_pkg::LEN_W-1:0]        report_len,
  // configuration
  input  logic                             cfg_write,
  input  logic [pqt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pqt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pqt_pkg::*;

  localparam int NAW  = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int NCW  = $clog2(NORMAL_DEPTH + 1);
  localparam int PAW  = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
  localparam int PCW  = $clog2(PRIO_DEPTH + 1);
  localparam int CMPW = (NCW > CAP_W) ? NCW : CAP_W;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ARRIVAL,
    SRC_PRIO,
    SRC_NORMAL
  } tx_src_t;

  // configuration registers
  logic [CAP_W-1:0] frame_capacity;
  logic             lb_enable;
  logic [QID_W-1:0] queue_index;

  // queue state
  logic [HANDLE_BITS-1:0] normal_mem [NORMAL_DEPTH];
  logic [HANDLE_BITS-1:0] prio_mem   [PRIO_DEPTH];
  logic [HANDLE_BITS-1:0] normal_rd, prio_rd;
  logic [NAW-1:0] normal_head, normal_head_next, normal_tail, normal_tail_next;
  logic [PAW-1:0] prio_head, prio_head_next, prio_tail, prio_tail_next;
  logic [NCW-1:0] normal_count, normal_count_next;
  logic [PCW-1:0] prio_count, prio_count_next;
  logic           link_on, link_on_next;
  logic [DROP_W-1:0] drop_counter, drop_counter_next;

  // result registers
  tx_src_t                tx_src, tx_src_next;
  logic [HANDLE_BITS-1:0] arr_handle;
  logic                   drop_flag, drop_flag_next;

  logic accept;
  logic normal_push, prio_push;
  logic over_cap;
  logic [CMPW-1:0] normal_count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // tail-drop limit check
  assign over_cap = (frame_capacity != '0) &&
                    (CMPW'(normal_count) >= CMPW'(frame_capacity));

  // next-state decision for one request
  always_comb begin
    normal_head_next  = normal_head;
    normal_tail_next  = normal_tail;
    normal_count_next = normal_count;
    prio_head_next    = prio_head;
    prio_tail_next    = prio_tail;
    prio_count_next   = prio_count;
    link_on_next      = link_on;
    drop_counter_next = drop_counter;
    tx_src_next       = SRC_NONE;
    drop_flag_next    = 1'b0;
    normal_push       = 1'b0;
    prio_push         = 1'b0;
    if (accept) begin
      if (req_type == REQ_FINISH) begin
        link_on_next = 1'b0;
        if (prio_count != '0) begin
          tx_src_next     = SRC_PRIO;
          link_on_next    = 1'b1;
          prio_count_next = prio_count - 1'b1;
          prio_head_next  = (prio_head == PAW'(PRIO_DEPTH - 1)) ? '0 : prio_head + 1'b1;
        end else if (normal_count != '0) begin
          tx_src_next       = SRC_NORMAL;
          link_on_next      = 1'b1;
          normal_count_next = normal_count - 1'b1;
          normal_head_next  = (normal_head == NAW'(NORMAL_DEPTH - 1)) ?
                              '0 : normal_head + 1'b1;
        end
      end else if (!link_on) begin
        tx_src_next  = SRC_ARRIVAL;
        link_on_next = 1'b1;
      end else begin
        if (is_control) begin
          if (prio_count < PCW'(PRIO_DEPTH)) begin
            prio_push       = 1'b1;
            prio_count_next = prio_count + 1'b1;
            prio_tail_next  = (prio_tail == PAW'(PRIO_DEPTH - 1)) ? '0 : prio_tail + 1'b1;
          end else begin
            drop_flag_next = 1'b1;
          end
        end else if (over_cap || (normal_count >= NCW'(NORMAL_DEPTH))) begin
          drop_flag_next = 1'b1;
        end else begin
          normal_push       = 1'b1;
          normal_count_next = normal_count + 1'b1;
          normal_tail_next  = (normal_tail == NAW'(NORMAL_DEPTH - 1)) ?
                              '0 : normal_tail + 1'b1;
        end
        if (drop_flag_next && (drop_counter != '1)) begin
          drop_counter_next = drop_counter + 1'b1;
        end
      end
    end
  end

  // control state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_capacity <= '0;
      lb_enable      <= 1'b0;
      queue_index    <= '0;
      normal_head    <= '0;
      normal_tail    <= '0;
      normal_count   <= '0;
      prio_head      <= '0;
      prio_tail      <= '0;
      prio_count     <= '0;
      link_on        <= 1'b0;
      drop_counter   <= '0;
      done           <= 1'b0;
      tx_src         <= SRC_NONE;
      drop_flag      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_CAP: frame_capacity <= cfg_data[CAP_W-1:0];
          CFG_LB_EN:     lb_enable      <= cfg_data[0];
          CFG_QUEUE_IDX: queue_index    <= cfg_data[QID_W-1:0];
          default: ;
        endcase
      end
      normal_head  <= normal_head_next;
      normal_tail  <= normal_tail_next;
      normal_count <= normal_count_next;
      prio_head    <= prio_head_next;
      prio_tail    <= prio_tail_next;
      prio_count   <= prio_count_next;
      link_on      <= link_on_next;
      drop_counter <= drop_counter_next;
      done         <= accept;
      tx_src       <= tx_src_next;
      drop_flag    <= drop_flag_next;
    end
  end

  // arriving handle, kept for a direct send
  always_ff @(posedge clk) begin
    if (accept) begin
      arr_handle <= pkt_handle;
    end
  end

  // FIFO RAMs: write at tail, registered read at head every cycle
  always_ff @(posedge clk) begin
    if (normal_push) begin
      normal_mem[normal_tail] <= pkt_handle;
    end
    normal_rd <= normal_mem[normal_head];
  end

  always_ff @(posedge clk) begin
    if (prio_push) begin
      prio_mem[prio_tail] <= pkt_handle;
    end
    prio_rd <= prio_mem[prio_head];
  end

  // result ports
  assign normal_count_ext = CMPW'(normal_count);

  always_comb begin
    case (tx_src)
      SRC_ARRIVAL: tx_handle = arr_handle;
      SRC_PRIO:    tx_handle = prio_rd;
      SRC_NORMAL:  tx_handle = normal_rd;
      default:     tx_handle = '0;
    endcase
  end

  assign tx_start     = (tx_src != SRC_NONE);
  assign dropped      = drop_flag;
  assign drop_total   = drop_counter;
  assign normal_len   = normal_count_ext[LEN_W-1:0];
  assign link_busy    = link_on;
  assign report_valid = lb_enable;
  assign report_queue = lb_enable ? queue_index : '0;
  assign report_len   = lb_enable ? normal_count_ext[LEN_W-1:0] : '0;

`ifndef SYNTHESIS
  // every accepted request yields exactly one strobe in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request gave no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without a request");

  // occupancy never passes the RAM depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (prio_count <= PCW'(PRIO_DEPTH)) && (normal_count <= NCW'(NORMAL_DEPTH)))
    else $error("FIFO count out of range");

  // a pending priority entry wins the next finish
  a_prio_first: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_FINISH) && (prio_count != '0) |=>
      done && (tx_src == SRC_PRIO))
    else $error("priority head not served first");

  // a drop bumps the counter unless saturated
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    done && dropped && ($past(drop_counter) != '1) |->
      drop_counter == $past(drop_counter) + 1'b1)
    else $error("drop not counted");
`endif

endmodule

@@ dv/priority_two_queue_transmitter_test.sv @@
// ---------------------------------------------------------------------------
// priority_two_queue_transmitter_test
// Self-checking bench for the strict-priority two-queue transmitter. Requests
// (packet arrivals and transmission-finished events) go in through the
// start/busy port. Each request's outcome is predicted by a local model of
// the link, both FIFOs, the drop counter and the registers. Every done strobe
// is compared field by field against the oldest prediction. The traffic
// covers directed corner cases, priority and normal FIFO overflow at the
// depth limit and at the configured capacity, and mixed random traffic under
// several register settings, with bursty sender pacing.
// ---------------------------------------------------------------------------
module priority_two_queue_transmitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pqt_pkg::*;

  localparam int HB             = HANDLE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 3;

  // packet kinds and an index that maps to no register
  localparam logic DATA_PKT = 1'b0;
  localparam logic CTRL_PKT = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic              tx_start;
    logic [HB-1:0]     tx_handle;
    logic              dropped;
    logic [DROP_W-1:0] drop_total;
    logic [LEN_W-1:0]  normal_len;
    logic              link_busy;
    logic              report_valid;
    logic [QID_W-1:0]  report_queue;
    logic [LEN_W-1:0]  report_len;
  } tx_outcome_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic req_type;
  logic [HB-1:0] pkt_handle;
  logic is_control;
  logic done;
  logic tx_start;
  logic [HB-1:0] tx_handle;
  logic dropped;
  logic [DROP_W-1:0] drop_total;
  logic [LEN_W-1:0] normal_len;
  logic link_busy;
  logic report_valid;
  logic [QID_W-1:0] report_queue;
  logic [LEN_W-1:0] report_len;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the link state and registers
  logic [HB-1:0]     normal_q[$];
  logic [HB-1:0]     prio_q[$];
  logic              line_active;
  logic [DROP_W-1:0] drops_seen;
  logic [CAP_W-1:0]  cap_limit;
  logic              lb_enable;
  logic [QID_W-1:0]  queue_id;

  tx_outcome_t pending_outcomes[$];
  int mismatches;
  int idle_cycles;
  int burst_left;

  priority_two_queue_transmitter uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .pkt_handle   (pkt_handle),
    .is_control   (is_control),
    .done         (done),
    .tx_start     (tx_start),
    .tx_handle    (tx_handle),
    .dropped      (dropped),
    .drop_total   (drop_total),
    .normal_len   (normal_len),
    .link_busy    (link_busy),
    .report_valid (report_valid),
    .report_queue (report_queue),
    .report_len   (report_len),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // outcome of one request; updates the local link state
  function automatic tx_outcome_t link_outcome(logic rt, logic [HB-1:0] h, logic ctl);
    tx_outcome_t r;
    logic over;
    r = '0;
    if (rt == REQ_FINISH) begin
      if (prio_q.size() != 0) begin
        r.tx_handle = prio_q.pop_front();
        r.tx_start = 1'b1;
      end else if (normal_q.size() != 0) begin
        r.tx_handle = normal_q.pop_front();
        r.tx_start = 1'b1;
      end
      line_active = r.tx_start;
    end else if (!line_active) begin
      r.tx_handle = h;
      r.tx_start = 1'b1;
      line_active = 1'b1;
    end else begin
      over = (cap_limit != 0) && (normal_q.size() >= int'(cap_limit));
      if (ctl) begin
        if (prio_q.size() < PRIO_DEPTH_DEF) prio_q.push_back(h);
        else r.dropped = 1'b1;
      end else if (over || normal_q.size() >= NORMAL_DEPTH_DEF) begin
        r.dropped = 1'b1;
      end else begin
        normal_q.push_back(h);
      end
      // counter sticks at all ones
      if (r.dropped && drops_seen != '1) drops_seen = drops_seen + 1'b1;
    end
    r.drop_total   = drops_seen;
    r.normal_len   = LEN_W'(normal_q.size());
    r.link_busy    = line_active;
    r.report_valid = lb_enable;
    r.report_queue = lb_enable ? queue_id : '0;
    r.report_len   = lb_enable ? LEN_W'(normal_q.size()) : '0;
    return r;
  endfunction

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // result checker: compare every done strobe against the oldest prediction
  always @(posedge clk) begin : check_results
    tx_outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = pending_outcomes.pop_front();
        flag_field("tx_start", 32'(want.tx_start), 32'(tx_start));
        flag_field("tx_handle", 32'(want.tx_handle), 32'(tx_handle));
        flag_field("dropped", 32'(want.dropped), 32'(dropped));
        flag_field("drop_total", want.drop_total, drop_total);
        flag_field("normal_len", 32'(want.normal_len), 32'(normal_len));
        flag_field("link_busy", 32'(want.link_busy), 32'(link_busy));
        flag_field("report_valid", 32'(want.report_valid), 32'(report_valid));
        flag_field("report_queue", 32'(want.report_queue), 32'(report_queue));
        flag_field("report_len", 32'(want.report_len), 32'(report_len));
      end
    end
  end

  // watchdog: no accepted request and no result for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request and hold it until accepted; start stays high
  task automatic send_request(logic rt, logic [HB-1:0] h, logic ctl);
    start <= 1'b1;
    req_type <= rt;
    pkt_handle <= h;
    is_control <= ctl;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_outcomes.push_back(link_outcome(rt, h, ctl));
  endtask

  // bursty sender: back-to-back runs with random gaps in between
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 5);
    end
  endtask

  task automatic send_random(int finish_pct, int ctrl_pct);
    logic rt;
    logic ctl;
    rt  = ($urandom_range(0, 99) < finish_pct) ? REQ_FINISH : REQ_ARRIVAL;
    ctl = ($urandom_range(0, 99) < ctrl_pct) ? CTRL_PKT : DATA_PKT;
    send_request(rt, HB'($urandom()), ctl);
    pace();
  endtask

  // drop start and wait until every outstanding result is back
  task automatic settle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      CFG_FRAME_CAP: cap_limit = d;
      CFG_LB_EN:     lb_enable = d[0];
      CFG_QUEUE_IDX: queue_id = d[QID_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits of the one- and two-bit registers are random filler
  task automatic apply_settings(int cap, logic lb, logic [QID_W-1:0] qid);
    settle();
    write_register(CFG_FRAME_CAP, CAP_W'(cap));
    write_register(CFG_LB_EN, {6'($urandom()), lb});
    write_register(CFG_QUEUE_IDX, {5'($urandom()), qid});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // corner cases: idle finish, idle send, priority order, capacity drop
  task automatic test_directed();
    send_request(REQ_FINISH, 16'h0000, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'hFFFF, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'h0000, CTRL_PKT);
    send_request(REQ_ARRIVAL, 16'h1234, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'hA5A5, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'h5A5A, CTRL_PKT);
    repeat (5) send_request(REQ_FINISH, 16'hFFFF, CTRL_PKT);
    send_request(REQ_FINISH, 16'h0001, DATA_PKT);
    // capacity of one, reports on from queue 3, all data bits set
    settle();
    write_register(CFG_FRAME_CAP, 7'd1);
    write_register(CFG_LB_EN, 7'h7F);
    write_register(CFG_QUEUE_IDX, 7'h7F);
    cfg_write <= 1'b0;
    @(posedge clk);
    send_request(REQ_ARRIVAL, 16'h00FF, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'hFF00, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'h0F0F, DATA_PKT);
    send_request(REQ_ARRIVAL, 16'hF0F0, CTRL_PKT);
    repeat (4) send_request(REQ_FINISH, 16'h0000, DATA_PKT);
  endtask

  // overrun the priority FIFO, then drain it
  task automatic test_prio_overflow();
    apply_settings(0, 1'b1, 2'd2);
    send_request(REQ_ARRIVAL, HB'($urandom()), DATA_PKT);
    repeat (PRIO_DEPTH_DEF + 3) begin
      send_request(REQ_ARRIVAL, HB'($urandom()), CTRL_PKT);
      pace();
    end
    while (prio_q.size() != 0 || normal_q.size() != 0) begin
      send_request(REQ_FINISH, HB'($urandom()), CTRL_PKT);
      pace();
    end
    send_request(REQ_FINISH, HB'($urandom()), DATA_PKT);
  endtask

  // fill the normal FIFO past its depth under the given capacity, then drain
  task automatic test_normal_overflow(int cap);
    apply_settings(cap, 1'($urandom()), 2'($urandom()));
    send_request(REQ_ARRIVAL, HB'($urandom()), DATA_PKT);
    repeat (NORMAL_DEPTH_DEF + 12) send_random(3, 3);
    while (prio_q.size() != 0 || normal_q.size() != 0) send_random(85, 30);
    send_request(REQ_FINISH, HB'($urandom()), DATA_PKT);
  endtask

  // mixed traffic under several settings, unmapped register index included
  task automatic test_mixed_traffic();
    int caps[5] = '{64, 3, 1, 0, 20};
    settle();
    write_register(CFG_UNMAPPED, 7'($urandom()));
    cfg_write <= 1'b0;
    @(posedge clk);
    foreach (caps[i]) begin
      apply_settings(caps[i], 1'($urandom()), 2'($urandom()));
      repeat (25) send_random($urandom_range(25, 60), 30);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_ARRIVAL;
    pkt_handle = '0;
    is_control = DATA_PKT;
    cfg_write = 1'b0;
    cfg_index = CFG_FRAME_CAP;
    cfg_data = '0;
    burst_left = 0;
    line_active = 1'b0;
    drops_seen = '0;
    cap_limit = '0;
    lb_enable = 1'b0;
    queue_id = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_prio_overflow();
    test_normal_overflow(0);
    test_normal_overflow(127);
    test_mixed_traffic();

    settle();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pqt_pkg.sv
sv/priority_two_queue_transmitter.sv
dv/priority_two_queue_transmitter_test.sv
